/* hdl/lpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_pkg - LRU page replacement shared definitions
// Sizes, miss codes and the lookup result passed from the frame table.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 10;
  localparam int PAGE_IN_W  = 10;
  localparam int ALLOT_W    = 5;
  localparam int CNT_W      = 32;

  localparam int PAGE_COUNT = 1 << PAGE_BITS;
  localparam int AGE_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int USED_W     = $clog2(MAX_FRAMES + 1);

  localparam logic [ALLOT_W-1:0] ALLOT_RESET = ALLOT_W'(16);
  localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};

  localparam logic [1:0] MISS_NONE       = 2'd0;
  localparam logic [1:0] MISS_COMPULSORY = 2'd1;
  localparam logic [1:0] MISS_CAPACITY   = 2'd2;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    logic  hit;
    logic  ev_valid;
    page_t ev_page;
  } lookup_t;

  // Zero acts as one frame; anything above the table size is clipped.
  function automatic logic [USED_W-1:0] eff_limit(input logic [ALLOT_W-1:0] allot);
    logic [USED_W-1:0] lim;
    if (allot == '0) begin
      lim = USED_W'(1);
    end else if (32'(allot) > MAX_FRAMES) begin
      lim = USED_W'(MAX_FRAMES);
    end else begin
      lim = USED_W'(allot);
    end
    return lim;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

/* hdl/lpr_seen.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_seen - seen-page bitmap
// One bit per page number, cleared by a sweep after reset. Registered read.
// ----------------------------------------------------------------------------
module lpr_seen
  import lpr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  rd_en,
  input  page_t rd_addr,
  output logic  rd_data,
  input  logic  set_en,
  input  page_t set_addr,
  output logic  busy
);

  logic  mem [PAGE_COUNT];
  page_t clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + PAGE_BITS'(1);
      if (clr_idx == PAGE_BITS'(PAGE_COUNT - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= 1'b0;
    end else if (set_en) begin
      mem[set_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/lpr_frames.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_frames - fully associative frame table with recency ranks
// Parallel tag compare, free-frame pick, LRU victim and rank update.
// ----------------------------------------------------------------------------
module lpr_frames
  import lpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  page_t              page,
  input  logic [ALLOT_W-1:0] allotted,
  output lookup_t            result
);

  page_t                   frame_page [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]   frame_valid;
  logic [AGE_W-1:0]        frame_age  [MAX_FRAMES];
  logic [USED_W-1:0]       frames_used;

  logic [MAX_FRAMES-1:0]   match;
  logic [MAX_FRAMES-1:0]   free_oh;
  logic [MAX_FRAMES-1:0]   victim_oh;
  logic [MAX_FRAMES-1:0]   sel;
  logic [AGE_W-1:0]        age_next [MAX_FRAMES];
  logic [AGE_W-1:0]        oldest_rank;
  logic [AGE_W-1:0]        hit_age;
  logic [AGE_W-1:0]        old_rank;
  page_t                   victim_page;
  logic                    hit;
  logic                    fill;

  assign oldest_rank = AGE_W'(frames_used - USED_W'(1));

  always_comb begin
    logic found;
    found       = 1'b0;
    hit_age     = '0;
    victim_page = '0;
    for (int f = 0; f < MAX_FRAMES; f++) begin
      match[f]     = frame_valid[f] && (frame_page[f] == page);
      victim_oh[f] = frame_valid[f] && (frame_age[f] == oldest_rank);
      free_oh[f]   = !frame_valid[f] && !found;
      found        = found | !frame_valid[f];
      hit_age      = hit_age | (match[f] ? frame_age[f] : '0);
      victim_page  = victim_page | (victim_oh[f] ? frame_page[f] : '0);
    end
  end

  assign hit      = |match;
  assign fill     = !hit && (frames_used < eff_limit(allotted)) && !(&frame_valid);
  assign old_rank = hit ? hit_age : oldest_rank;
  assign sel      = hit ? match : (fill ? free_oh : victim_oh);

  // On a fill every resident frame ages; otherwise only those younger than the target.
  always_comb begin
    for (int f = 0; f < MAX_FRAMES; f++) begin
      if (sel[f]) begin
        age_next[f] = '0;
      end else if (frame_valid[f] && (fill || frame_age[f] < old_rank)) begin
        age_next[f] = frame_age[f] + AGE_W'(1);
      end else begin
        age_next[f] = frame_age[f];
      end
    end
  end

  assign result.hit      = hit;
  assign result.ev_valid = !hit && !fill;
  assign result.ev_page  = (!hit && !fill) ? victim_page : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      frames_used <= '0;
      for (int f = 0; f < MAX_FRAMES; f++) begin
        frame_age[f] <= '0;
      end
    end else if (step) begin
      for (int f = 0; f < MAX_FRAMES; f++) begin
        frame_age[f] <= age_next[f];
      end
      if (fill) begin
        frame_valid <= frame_valid | sel;
        frames_used <= frames_used + USED_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int f = 0; f < MAX_FRAMES; f++) begin
      if (step && !hit && sel[f]) begin
        frame_page[f] <= page;
      end
    end
  end

  a_used_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(frame_valid) == int'(frames_used))
    else $error("occupancy count disagrees with valid frames");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("page resident in more than one frame");

  a_miss_target: assert property (@(posedge clk) disable iff (rst)
    step && !hit |-> $onehot(sel))
    else $error("miss without exactly one target frame");

endmodule

/* hdl/lru_page_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement - fully associative LRU page replacement
// Classifies each page reference as hit, compulsory or capacity miss.
// ----------------------------------------------------------------------------
// Input channel: page_number with in_valid/in_stall; a transfer takes place
// at a clock edge with in_valid high and in_stall low.
// Output channel: hit, miss_kind, evicted_valid, evicted_page and the three
// running totals with out_valid/out_stall, one result per reference.
// frames_allotted is written through cfg_write_en/cfg_write_data while idle, a
// rule for the user that the block itself does not enforce. A reference waits
// in the lookup register, then moves to the output registers: one reference per
// cycle unless the output stall or bitmap sweep holds it. Tag compare and rank
// update are combinational; the seen bitmap is read as a reference is accepted.
// Reset (rst, synchronous) empties the frame table, zeroes the totals and sets
// the allotment to 16, then sweeps all 1024 seen bits clear with in_stall high;
// cfg writes still land. A stall on the output holds the result; the lookup
// register then holds one more reference and in_stall rises.
// ----------------------------------------------------------------------------
module lru_page_replacement
  import lpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [ALLOT_W-1:0]   cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PAGE_IN_W-1:0] page_number,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic [1:0]           miss_kind,
  output logic                 evicted_valid,
  output logic [PAGE_IN_W-1:0] evicted_page,
  output logic [CNT_W-1:0]     compulsory_total,
  output logic [CNT_W-1:0]     capacity_total,
  output logic [CNT_W-1:0]     access_total
);

  logic [ALLOT_W-1:0] frames_allotted;
  logic               s1_valid;
  page_t              s1_page;
  logic               last_set_valid;
  page_t              last_set_page;
  logic               seen_q;
  logic               seen_busy;
  logic               seen_now;
  logic               accept;
  logic               s1_move;
  logic               set_en;
  lookup_t            lookup;

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = seen_busy || (s1_valid && !s1_move);
  assign accept   = in_valid && !in_stall;
  assign set_en   = s1_move && !lookup.hit;

  // Bitmap read was issued before the previous reference's set landed.
  assign seen_now = seen_q || (last_set_valid && (last_set_page == s1_page));

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_allotted <= ALLOT_RESET;
    end else if (cfg_write_en) begin
      frames_allotted <= cfg_write_data;
    end
  end

  lpr_seen u_seen (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (page_number[PAGE_BITS-1:0]),
    .rd_data  (seen_q),
    .set_en   (set_en),
    .set_addr (s1_page),
    .busy     (seen_busy)
  );

  lpr_frames u_frames (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_move),
    .page     (s1_page),
    .allotted (frames_allotted),
    .result   (lookup)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_page <= page_number[PAGE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      last_set_valid   <= 1'b0;
      compulsory_total <= '0;
      capacity_total   <= '0;
      access_total     <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid    <= 1'b1;
        access_total <= sat_inc(access_total);
        if (!lookup.hit) begin
          last_set_valid <= 1'b1;
          if (seen_now) begin
            capacity_total <= sat_inc(capacity_total);
          end else begin
            compulsory_total <= sat_inc(compulsory_total);
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (set_en) begin
      last_set_page <= s1_page;
    end
    if (s1_move) begin
      hit           <= lookup.hit;
      evicted_valid <= lookup.ev_valid;
      evicted_page  <= PAGE_IN_W'(lookup.ev_page);
      if (lookup.hit) begin
        miss_kind <= MISS_NONE;
      end else if (seen_now) begin
        miss_kind <= MISS_CAPACITY;
      end else begin
        miss_kind <= MISS_COMPULSORY;
      end
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    seen_busy |-> !accept)
    else $error("reference taken during bitmap clear");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted reference lost before lookup");

  a_move_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("lookup completed without a result");

  a_hit_never_evicts: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !evicted_valid && (miss_kind == MISS_NONE))
    else $error("hit reported with eviction or miss class");

endmodule

/* bench/lru_replacement_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_replacement_checker - result checker for the LRU page replacement block
// Watches both channels and the allotment port. It keeps its own frame table,
// recency ranks, seen-page map and totals, works out the outcome of every
// accepted reference, and compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module lru_replacement_checker
  import lpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [ALLOT_W-1:0]   cfg_write_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [PAGE_IN_W-1:0] page_number,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 hit,
  input  logic [1:0]           miss_kind,
  input  logic                 evicted_valid,
  input  logic [PAGE_IN_W-1:0] evicted_page,
  input  logic [CNT_W-1:0]     compulsory_total,
  input  logic [CNT_W-1:0]     capacity_total,
  input  logic [CNT_W-1:0]     access_total,
  output int                   errors,
  output int                   outstanding,
  output int                   hits_seen,
  output int                   evictions_seen
);

  typedef struct packed {
    logic              hit;
    logic [1:0]        kind;
    logic              ev_valid;
    page_t             ev_page;
    logic [CNT_W-1:0]  comp;
    logic [CNT_W-1:0]  cap;
    logic [CNT_W-1:0]  acc;
  } outcome_t;

  page_t              slot_page  [MAX_FRAMES];
  logic               slot_valid [MAX_FRAMES];
  int                 slot_rank  [MAX_FRAMES];
  logic               seen_page  [PAGE_COUNT];
  int                 slots_used;
  logic [ALLOT_W-1:0] allot;
  logic [CNT_W-1:0]   n_comp, n_cap, n_acc;
  outcome_t           pending_outcomes [$];

  // Slot f becomes most recent; younger valid slots age by one.
  function automatic void promote(input int f, input int old_rank);
    for (int k = 0; k < MAX_FRAMES; k++) begin
      if (k != f && slot_valid[k] && slot_rank[k] < old_rank) slot_rank[k]++;
    end
    slot_rank[f] = 0;
  endfunction

  function automatic outcome_t reference_page(input logic [PAGE_IN_W-1:0] raw);
    outcome_t o;
    page_t    p;
    int       hit_at, slot, limit, oldest;
    o      = '0;
    o.kind = MISS_NONE;
    p      = page_t'(raw);
    hit_at = -1;
    for (int f = 0; f < MAX_FRAMES; f++) begin
      if (hit_at < 0 && slot_valid[f] && slot_page[f] == p) hit_at = f;
    end
    if (hit_at >= 0) begin
      o.hit = 1'b1;
      promote(hit_at, slot_rank[hit_at]);
    end else begin
      limit = (allot == '0) ? 1 : ((int'(allot) > MAX_FRAMES) ? MAX_FRAMES : int'(allot));
      slot  = -1;
      if (slots_used < limit) begin
        for (int f = 0; f < MAX_FRAMES; f++) begin
          if (slot < 0 && !slot_valid[f]) slot = f;
        end
      end
      if (slot >= 0) begin
        slot_valid[slot] = 1'b1;
        slot_page[slot]  = p;
        slots_used++;
        promote(slot, MAX_FRAMES + 1);
      end else begin
        oldest = 0;
        for (int f = 0; f < MAX_FRAMES; f++) begin
          if (slot_valid[f] && (slot < 0 || slot_rank[f] > oldest)) begin
            slot   = f;
            oldest = slot_rank[f];
          end
        end
        if (slot >= 0) begin
          o.ev_valid      = 1'b1;
          o.ev_page       = slot_page[slot];
          slot_page[slot] = p;
          promote(slot, oldest);
        end
      end
      if (seen_page[p]) begin
        o.kind = MISS_CAPACITY;
        if (~&n_cap) n_cap++;
      end else begin
        o.kind       = MISS_COMPULSORY;
        seen_page[p] = 1'b1;
        if (~&n_comp) n_comp++;
      end
    end
    if (~&n_acc) n_acc++;
    o.comp = n_comp;
    o.cap  = n_cap;
    o.acc  = n_acc;
    return o;
  endfunction

  task automatic check_field(input string what, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    outcome_t want;
    if (rst) begin
      for (int f = 0; f < MAX_FRAMES; f++) begin
        slot_page[f]  = '0;
        slot_valid[f] = 1'b0;
        slot_rank[f]  = 0;
      end
      for (int i = 0; i < PAGE_COUNT; i++) seen_page[i] = 1'b0;
      slots_used     = 0;
      allot          = ALLOT_RESET;
      n_comp         = '0;
      n_cap          = '0;
      n_acc          = '0;
      errors         = 0;
      hits_seen      = 0;
      evictions_seen = 0;
      pending_outcomes.delete();
      outstanding <= 0;
    end else begin
      if (cfg_write_en) allot = cfg_write_data;
      // results first: nothing leaves in the cycle it was taken in
      if (out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          errors++;
          $display("%0t: result transfer with no reference outstanding", $time);
        end else begin
          want = pending_outcomes.pop_front();
          check_field("hit", CNT_W'(want.hit), CNT_W'(hit));
          check_field("miss_kind", CNT_W'(want.kind), CNT_W'(miss_kind));
          check_field("evicted_valid", CNT_W'(want.ev_valid), CNT_W'(evicted_valid));
          check_field("evicted_page", CNT_W'(want.ev_page), CNT_W'(evicted_page));
          check_field("compulsory_total", want.comp, compulsory_total);
          check_field("capacity_total", want.cap, capacity_total);
          check_field("access_total", want.acc, access_total);
          if (want.hit) hits_seen++;
          if (want.ev_valid) evictions_seen++;
        end
      end
      if (in_valid && !in_stall) pending_outcomes.push_back(reference_page(page_number));
      outstanding <= pending_outcomes.size();
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench top for lru_page_replacement
// Drives page references in bursts with random gaps, stalls the result side
// on its own pattern, and moves the frame allotment through in-range and
// out-of-range values between drained phases. The checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import lpr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 10;
  localparam int PHASE_REFS  = 143;
  localparam int HOLD_AT     = 360;
  localparam int HOLD_CYCLES = 150;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write_en;
  logic [ALLOT_W-1:0]   cfg_write_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [PAGE_IN_W-1:0] page_number;
  logic                 out_valid;
  logic                 out_stall;
  logic                 hit;
  logic [1:0]           miss_kind;
  logic                 evicted_valid;
  logic [PAGE_IN_W-1:0] evicted_page;
  logic [CNT_W-1:0]     compulsory_total;
  logic [CNT_W-1:0]     capacity_total;
  logic [CNT_W-1:0]     access_total;

  int errors, outstanding, hits_seen, evictions_seen;
  int sent_count  = 0;
  int burst_left  = 0;
  int cycle_count = 0;

  logic [ALLOT_W-1:0] allot_plan [PHASES] = '{5'd16, 5'd1, 5'd5, 5'd17, 5'd0,
                                              5'd9, 5'd31, 5'd2, 5'd16, 5'd12};

  lru_page_replacement dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .page_number      (page_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .hit              (hit),
    .miss_kind        (miss_kind),
    .evicted_valid    (evicted_valid),
    .evicted_page     (evicted_page),
    .compulsory_total (compulsory_total),
    .capacity_total   (capacity_total),
    .access_total     (access_total)
  );

  lru_replacement_checker chk (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .page_number      (page_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .hit              (hit),
    .miss_kind        (miss_kind),
    .evicted_valid    (evicted_valid),
    .evicted_page     (evicted_page),
    .compulsory_total (compulsory_total),
    .capacity_total   (capacity_total),
    .access_total     (access_total),
    .errors           (errors),
    .outstanding      (outstanding),
    .hits_seen        (hits_seen),
    .evictions_seen   (evictions_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stall modes, plus one long hold-off mid-run
  initial begin : result_side
    int  mode, run_left, hold_left, step;
    bit  held;
    run_left  = 0;
    hold_left = 0;
    held      = 1'b0;
    mode      = 0;
    step      = 0;
    forever begin
      if (!held && sent_count >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 3);
          run_left = $urandom_range(10, 120);
        end
        run_left--;
        step++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= ((step % 7) >= 4);
        endcase
      end
      @(posedge clk);
    end
  end

  task automatic offer_page(input page_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid    <= 1'b1;
    page_number <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_allotment(input logic [ALLOT_W-1:0] v);
    settle();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  initial begin : stimulus
    page_t pg, base;
    int    ws, pick;
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    in_valid       <= 1'b0;
    page_number    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, hits, then allotment cut below occupancy
    offer_page(10'd0);   offer_page(10'd1023); offer_page(10'h2AA); offer_page(10'h155);
    offer_page(10'd0);   offer_page(10'd1023);
    write_allotment(5'd2);
    offer_page(10'h155); offer_page(10'd7);    offer_page(10'd0);   offer_page(10'h2AA);
    write_allotment(5'd0);
    offer_page(10'd9);   offer_page(10'd9);    offer_page(10'd1023);
    write_allotment(5'd31);
    offer_page(10'd1);   offer_page(10'd2);    offer_page(10'd3);   offer_page(10'd1);
    write_allotment(5'd1);
    offer_page(10'd1);   offer_page(10'd5);    offer_page(10'd1);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_allotment(allot_plan[ph]);
      ws   = $urandom_range(1, 2 * int'(allot_plan[ph]) + 2);
      base = page_t'($urandom);
      for (int n = 0; n < PHASE_REFS; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) pg = base + page_t'($urandom_range(0, ws - 1));
        else if (pick < 9) pg = page_t'($urandom);
        else pg = ($urandom_range(0, 1) == 1) ? '1 : '0;
        if (ph == 5 && n == PHASE_REFS / 2) settle();
        offer_page(pg);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Run covered %0d references: %0d hits, %0d misses, %0d evictions.",
             sent_count, hits_seen, sent_count - hits_seen, evictions_seen);
    $display("Allotments 0, 1, 2, 5, 9, 12, 16, 17 and 31 used, with a long result hold-off.");
    if (errors == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
